// ----- hdl/bcu_pkg.sv -----
package bcu_pkg;

	localparam int unsigned DivBits = 32;

	localparam logic [31:0] FineOffset = 32'd64000;
	localparam logic [31:0] PressBase  = 32'd1048576;
	localparam logic [31:0] PressScale = 32'd3125;
	localparam logic [31:0] DenomBias  = 32'd32768;
	localparam logic [31:0] RoundHalf  = 32'd128;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PLOW    = 2'd1,
		REG_PHIGH   = 2'd2,
		REG_PNINE   = 2'd3
	} reg_idx_t;

	// side data carried along the divider
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] den;
		logic        dz;
		logic        dbl;
	} div_side_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// ----- hdl/barometric_compensation_unit.sv -----
// throughput: one beat per cycle; nine arithmetic stages, a 32-stage
// restoring divider (one quotient bit per stage) and three correction stages
// the whole pipeline holds while the output beat is not taken
// reset clears all valid bits and the calibration registers to zero
module barometric_compensation_unit
	import bcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // temperature_centi[31:0], pressure_pa[63:32]
	output logic [0:0]  m_tuser,   // pressure_valid
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [47:0] tc_q;
	logic [63:0] pl_q, ph_q;
	logic [15:0] p9_q;
	reg_idx_t    widx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pl_q <= '0;
			ph_q <= '0;
			p9_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				REG_TEMP:  tc_q <= pwdata[47:0];
				REG_PLOW:  pl_q <= pwdata;
				REG_PHIGH: ph_q <= pwdata;
				REG_PNINE: p9_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_TEMP:  prdata = {16'd0, tc_q};
			REG_PLOW:  prdata = pl_q;
			REG_PHIGH: prdata = ph_q;
			REG_PNINE: prdata = {48'd0, p9_q};
			default:   prdata = '0;
		endcase
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, tc_q[15:0]};
	assign t2 = sx16(tc_q[31:16]);
	assign t3 = sx16(tc_q[47:32]);
	assign p1 = {16'd0, pl_q[15:0]};
	assign p2 = sx16(pl_q[31:16]);
	assign p3 = sx16(pl_q[47:32]);
	assign p4 = sx16(pl_q[63:48]);
	assign p5 = sx16(ph_q[15:0]);
	assign p6 = sx16(ph_q[31:16]);
	assign p7 = sx16(ph_q[47:32]);
	assign p8 = sx16(ph_q[63:48]);
	assign p9 = sx16(p9_q);

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [19:0] ut_s1, up_s1, up_s2, up_s3, up_s4, up_s5, up_s6, up_s7;
	logic [31:0] m1_s2, m2_s2;
	logic [31:0] v1_s3, m3_s3;
	logic [31:0] fine_s4;
	logic [31:0] temp_s5, sq_s5, mx5_s5, mp2_s5;
	logic [31:0] temp_s6, mx5_s6, mp2_s6, x2a_s6, mp3_s6;
	logic [31:0] temp_s7, x2_s7, d0_s7;
	logic [31:0] temp_s8, dm_s8, pn_s8;
	logic [31:0] temp_s9, den_s9, p_s9;

	logic [31:0] a_c, b_c, bb_c, x1_c, q_c, fine_c, sqc, x2_c, d0_c, den_c;
	always_comb begin
		a_c    = {15'd0, ut_s1[19:3]} - {t1[30:0], 1'b0};
		b_c    = {16'd0, ut_s1[19:4]} - t1;
		bb_c   = $signed(m2_s2) >>> 12;
		fine_c = v1_s3 + 32'($signed(m3_s3) >>> 14);
		x1_c   = 32'($signed(fine_s4) >>> 1) - FineOffset;
		q_c    = $signed(x1_c) >>> 2;
		sqc    = 32'($signed(sq_s5) >>> 13);
		x2_c   = 32'($signed(x2a_s6 + {mx5_s6[30:0], 1'b0}) >>> 2) + {p4[15:0], 16'd0};
		d0_c   = $signed(32'($signed(mp3_s6) >>> 3) + 32'($signed(mp2_s6) >>> 1)) >>> 18;
		den_c  = $signed(dm_s8) >>> 15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ut_s1   <= s_tdata[19:0];
			up_s1   <= s_tdata[39:20];
			m1_s2   <= a_c * t2;
			m2_s2   <= b_c * b_c;
			up_s2   <= up_s1;
			v1_s3   <= $signed(m1_s2) >>> 11;
			m3_s3   <= bb_c * t3;
			up_s3   <= up_s2;
			fine_s4 <= fine_c;
			up_s4   <= up_s3;
			temp_s5 <= $signed({fine_s4[29:0], 2'b00} + fine_s4 + RoundHalf) >>> 8;
			sq_s5   <= q_c * q_c;
			mx5_s5  <= x1_c * p5;
			mp2_s5  <= p2 * x1_c;
			up_s5   <= up_s4;
			temp_s6 <= temp_s5;
			mx5_s6  <= mx5_s5;
			mp2_s6  <= mp2_s5;
			x2a_s6  <= 32'($signed(sq_s5) >>> 11) * p6;
			mp3_s6  <= p3 * sqc;
			up_s6   <= up_s5;
			temp_s7 <= temp_s6;
			x2_s7   <= x2_c;
			d0_s7   <= d0_c;
			up_s7   <= up_s6;
			temp_s8 <= temp_s7;
			dm_s8   <= (DenomBias + d0_s7) * p1;
			pn_s8   <= (PressBase - {12'd0, up_s7}) - 32'($signed(x2_s7) >>> 12);
			temp_s9 <= temp_s8;
			den_s9  <= den_c;
			p_s9    <= pn_s8 * PressScale;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [31:0] rem_s [0:DivBits];
	logic [31:0] nq_s  [0:DivBits];
	div_side_t   side_s [0:DivBits];
	logic        vd_s  [0:DivBits];

	assign rem_s[0]       = '0;
	assign nq_s[0]        = p_s9[31] ? p_s9 : {p_s9[30:0], 1'b0};
	assign side_s[0].temp = temp_s9;
	assign side_s[0].den  = den_s9;
	assign side_s[0].dz   = (den_s9 == '0);
	assign side_s[0].dbl  = p_s9[31];
	assign vd_s[0]        = v_s9;

	for (genvar g = 0; g < DivBits; g++) begin : g_div
		logic [32:0] sh, diff;
		assign sh   = {rem_s[g], nq_s[g][31]};
		assign diff = sh - {1'b0, side_s[g].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[g+1] <= 1'b0;
			end else if (adv) begin
				vd_s[g+1] <= vd_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[g+1] <= side_s[g];
				if (!diff[32]) begin
					rem_s[g+1] <= diff[31:0];
					nq_s[g+1]  <= {nq_s[g][30:0], 1'b1};
				end else begin
					rem_s[g+1] <= sh[31:0];
					nq_s[g+1]  <= {nq_s[g][30:0], 1'b0};
				end
			end
		end
	end

	// correction stages
	logic        v_s10, v_s11;
	logic [31:0] p_s10, m_s10, mw2_s10, temp_s10, p_s11, w1m_s11, mw2_s11, temp_s11;
	logic        dz_s10, dz_s11;
	logic [31:0] pq_c, corr_c;

	assign pq_c   = side_s[DivBits].dbl ? {nq_s[DivBits][30:0], 1'b0} : nq_s[DivBits];
	assign corr_c = $signed(32'($signed(w1m_s11) >>> 12) + 32'($signed(mw2_s11) >>> 13) + p7)
		>>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			v_s10    <= vd_s[DivBits];
			v_s11    <= v_s10;
			m_tvalid <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s10    <= pq_c;
			m_s10    <= {3'd0, pq_c[31:3]} * {3'd0, pq_c[31:3]};
			mw2_s10  <= {2'd0, pq_c[31:2]} * p8;
			temp_s10 <= side_s[DivBits].temp;
			dz_s10   <= side_s[DivBits].dz;
			p_s11    <= p_s10;
			w1m_s11  <= p9 * {13'd0, m_s10[31:13]};
			mw2_s11  <= mw2_s10;
			temp_s11 <= temp_s10;
			dz_s11   <= dz_s10;
			m_tdata[31:0]  <= temp_s11;
			m_tdata[63:32] <= dz_s11 ? '0 : p_s11 + corr_c;
			m_tuser[0]     <= !dz_s11;
		end
	end

endmodule

// ----- dv/barometric_compensation_unit_tb.sv -----
`timescale 1ns / 100ps

module barometric_compensation_unit_tb;
	import bcu_pkg::*;

	typedef struct packed {
		logic [31:0] temp_centi;
		logic [31:0] press_pa;
		logic        press_ok;
	} comp_result_t;

	function automatic logic [31:0] sra32(input logic [31:0] x, input int s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	class compensation_scoreboard;
		logic [47:0] tcoef;
		logic [63:0] plow;
		logic [63:0] phigh;
		logic [15:0] pnine;
		comp_result_t pending[$];
		int errors;
		int checked;
		int zero_den;
		int top_set;

		function void compensate(input logic [19:0] ut, input logic [19:0] up);
			logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic [31:0] a, b, v1, v2, fine, x1, q, sq, x2, den, p, w1, w2, pq;
			comp_result_t r;
			t1 = {16'd0, tcoef[15:0]};
			t2 = ext16(tcoef[31:16]);
			t3 = ext16(tcoef[47:32]);
			p1 = {16'd0, plow[15:0]};
			p2 = ext16(plow[31:16]);
			p3 = ext16(plow[47:32]);
			p4 = ext16(plow[63:48]);
			p5 = ext16(phigh[15:0]);
			p6 = ext16(phigh[31:16]);
			p7 = ext16(phigh[47:32]);
			p8 = ext16(phigh[63:48]);
			p9 = ext16(pnine);
			a = ({12'd0, ut} >> 3) - (t1 << 1);
			v1 = sra32(a * t2, 11);
			b = ({12'd0, ut} >> 4) - t1;
			v2 = sra32(sra32(b * b, 12) * t3, 14);
			fine = v1 + v2;
			r.temp_centi = sra32(fine * 32'd5 + RoundHalf, 8);
			x1 = sra32(fine, 1) - FineOffset;
			q = sra32(x1, 2);
			sq = q * q;
			x2 = sra32(sq, 11) * p6;
			x2 = x2 + ((x1 * p5) << 1);
			x2 = sra32(x2, 2) + (p4 << 16);
			den = sra32(sra32(p3 * sra32(sq, 13), 3) + sra32(p2 * x1, 1), 18);
			den = sra32((DenomBias + den) * p1, 15);
			if (den == 0) begin
				r.press_pa = '0;
				r.press_ok = 1'b0;
				zero_den++;
			end else begin
				p = ((PressBase - {12'd0, up}) - sra32(x2, 12)) * PressScale;
				if (p[31]) begin
					pq = p / den;
					p = pq << 1;
					top_set++;
				end else begin
					pq = p << 1;
					p = pq / den;
				end
				w1 = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
				w2 = sra32((p >> 2) * p8, 13);
				r.press_pa = p + sra32(w1 + w2 + p7, 4);
				r.press_ok = 1'b1;
			end
			pending.push_back(r);
		endfunction

		function void check_beat(input logic [63:0] data, input logic okbit);
			comp_result_t e;
			checked++;
			if (pending.size() == 0) begin
				report_error("output beat with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.temp_centi)
				report_error($sformatf("temperature %0d, expected %0d",
					$signed(data[31:0]), $signed(e.temp_centi)));
			if (data[63:32] !== e.press_pa)
				report_error($sformatf("pressure %0d, expected %0d",
					data[63:32], e.press_pa));
			if (okbit !== e.press_ok)
				report_error($sformatf("pressure valid %b, expected %b",
					okbit, e.press_ok));
		endfunction

		function void report_error(input string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // raw_temperature[19:0], raw_pressure[39:20]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // temperature_centi[31:0], pressure_pa[63:32]
	logic [0:0]  m_tuser;   // pressure_valid
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	compensation_scoreboard sb;
	int cycles = 0;
	bit no_idle;
	bit hold_sink;
	int beats_sent;

	barometric_compensation_unit dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold while the sender keeps offering samples
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata, m_tuser[0]);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (150) begin
					@(posedge clk);
					if (m_tvalid && m_tready)
						sb.check_beat(m_tdata, m_tuser[0]);
				end
				hold_sink = 0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				m_tready <= 1'b0;
				repeat (gap) begin
					@(posedge clk);
					if (m_tvalid && m_tready)
						sb.check_beat(m_tdata, m_tuser[0]);
				end
			end
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TEMP:  sb.tcoef = value[47:0];
			REG_PLOW:  sb.plow = value;
			REG_PHIGH: sb.phigh = value;
			REG_PNINE: sb.pnine = value[15:0];
		endcase
	endtask

	task automatic send_sample(input logic [19:0] ut, input logic [19:0] up);
		int gap;
		if (!no_idle && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {up, ut};
		do @(posedge clk); while (!s_tready);
		sb.compensate(ut, up);
		beats_sent++;
	endtask

	task automatic drain_pipe;
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// random field inside the usual range of a real sensor, or fully random
	task automatic program_coefs(input bit realistic);
		logic [63:0] lo, hi;
		if (realistic) begin
			lo = {16'($urandom_range(0, 4000)), 16'(-$urandom_range(0, 8000) - 1),
				16'($urandom_range(0, 6000) - 3000), 16'($urandom_range(30000, 40000))};
			hi = {16'($urandom_range(0, 8000) - 4000), 16'($urandom_range(0, 800)),
				16'(-$urandom_range(0, 20)), 16'($urandom_range(0, 500) - 250)};
			reg_write(REG_TEMP, {16'd0, 16'(-1000 - $urandom_range(0, 2000)),
				16'($urandom_range(20000, 30000)), 16'($urandom_range(25000, 32000))});
			reg_write(REG_PNINE, 64'($urandom_range(3000, 8000)));
		end else begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			reg_write(REG_TEMP, {$urandom, $urandom});
			reg_write(REG_PNINE, {$urandom, $urandom});
		end
		reg_write(REG_PLOW, lo);
		reg_write(REG_PHIGH, hi);
	endtask

	initial begin
		logic [19:0] ut, up;
		sb = new();
		no_idle = 0;
		hold_sink = 0;
		beats_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sb.tcoef = '0;
		sb.plow = '0;
		sb.phigh = '0;
		sb.pnine = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero calibration gives a zero denominator
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		drain_pipe();

		// extremes of every coefficient, and a denominator of exactly zero through P1
		reg_write(REG_TEMP, 64'h0000_8000_7FFF_FFFF);
		reg_write(REG_PLOW, 64'h7FFF_8000_7FFF_FFFF);
		reg_write(REG_PHIGH, 64'h8000_7FFF_8000_7FFF);
		reg_write(REG_PNINE, 64'h8000);
		send_sample(20'd0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'd0);
		send_sample(20'h55555, 20'hAAAAA);
		send_sample(20'hAAAAA, 20'h55555);
		drain_pipe();
		reg_write(REG_TEMP, 64'h0000_7FFF_8000_0000);
		reg_write(REG_PLOW, 64'h8000_7FFF_8000_0001);
		reg_write(REG_PHIGH, 64'h7FFF_8000_7FFF_8000);
		reg_write(REG_PNINE, 64'h7FFF);
		send_sample(20'd0, 20'd0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h80000, 20'h80000);
		drain_pipe();
		// typical calibration, typical and extreme readings; low readings set the top bit
		reg_write(REG_TEMP, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
		reg_write(REG_PLOW, {16'd2855, 16'h0D0, 16'd11231, 16'd36477} | 64'h0);
		reg_write(REG_PLOW, {16'd2855, 16'd208, 16'hD4BD, 16'd36477});
		reg_write(REG_PHIGH, {16'hEA2E, 16'd15500, 16'hFFF9, 16'd140});
		reg_write(REG_PNINE, 64'd6000);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'd519888, 20'd0);
		send_sample(20'd519888, 20'hFFFFF);
		send_sample(20'd0, 20'd300000);
		send_sample(20'hFFFFF, 20'd300000);
		drain_pipe();

		for (int phase = 0; phase < 8; phase++) begin
			program_coefs(phase % 4 != 3);
			if (phase == 6)
				no_idle = 1;
			for (int i = 0; i < 66; i++) begin
				if (phase == 2 && i == 5)
					hold_sink = 1;
				if ($urandom_range(0, 9) < 8) begin
					ut = 20'($urandom_range(400000, 600000));
					up = 20'($urandom_range(200000, 700000));
				end else begin
					ut = 20'($urandom);
					up = 20'($urandom);
				end
				send_sample(ut, up);
				// sender waits for all results once
				if (phase == 4 && i == 30) begin
					s_tvalid <= 1'b0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			drain_pipe();
		end

		$display("%0d samples sent, %0d results checked over several calibrations",
			beats_sent, sb.checked);
		$display("%0d zero-denominator results, %0d with top bit of scaled pressure set",
			sb.zero_den, sb.top_set);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/bcu_pkg.sv
hdl/barometric_compensation_unit.sv
dv/barometric_compensation_unit_tb.sv
